### rtl/sap_pkg.sv
// Shared types and constants for the shelf atlas packer.
package sap_pkg;

  // Largest page edge that the canvas register holds.
  localparam logic [13:0] MAX_CANVAS = 14'd8192;

  // Number of pages available, capped by the 4-bit page field.
  localparam int unsigned MAX_PAGES = 16;
  localparam logic [4:0]  PAGE_LIMIT = (MAX_PAGES > 16) ? 5'd16 : 5'(MAX_PAGES);

  // Configuration register indexes.
  localparam int unsigned        CFG_IDX_W       = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD         = 1'd1;
  localparam int unsigned        CFG_DATA_W      = 14;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_TOO_BIG = 2'd1,
    ST_NO_PAGE = 2'd2
  } status_e;

  // Configuration seen by the placement logic.
  typedef struct packed {
    logic [13:0] canvas_size;
    logic [7:0]  pad;
  } cfg_t;

  // One rectangle request.
  typedef struct packed {
    logic        restart;
    logic [13:0] rect_w;
    logic [13:0] rect_h;
  } in_req_t;

  // One placement result.
  typedef struct packed {
    logic [12:0] pos_x;
    logic [12:0] pos_y;
    logic [3:0]  page_index;
    status_e     status;
    logic [26:0] used_area;
  } out_rsp_t;

endpackage

### rtl/shelf_atlas_packer_top.sv
// An accepted request is held in the input register; when it is processed, its result
// is loaded into the result register and offered from there.
// Throughput: one rectangle per cycle unless a result is stalled downstream; the
// placement path between the input and result registers has a single 14x14 multiply.
// A new request enters an empty input register while a finished result waits downstream.
// Reset clears the packing state, the handshake valids and sets page edge 1024, pad 2.
module shelf_atlas_packer_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sap_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sap_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sap_pkg::in_req_t                in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output sap_pkg::out_rsp_t               out_rsp_o
);
  import sap_pkg::*;

  cfg_t     cfg;
  logic     in_valid_q;
  in_req_t  in_req_q;
  logic     out_valid_q;
  out_rsp_t out_rsp_q;
  out_rsp_t rsp;
  logic     fire;

  // A held request is processed when the result register is free or draining.
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  sap_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sap_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .req_i  (in_req_q),
    .cfg_i  (cfg),
    .rsp_o  (rsp)
  );

  // Input register and result register valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_req_q <= in_req_i;
    end
    if (fire) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

### rtl/sap_cfg.sv
// Configuration registers: page edge and padding.
module sap_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sap_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sap_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output sap_pkg::cfg_t                   cfg_o
);
  import sap_pkg::*;

  logic [13:0] canvas_q, canvas_d;
  logic [7:0]  pad_q, pad_d;

  // Decode a write; the page edge saturates at the largest supported size.
  always_comb begin
    canvas_d = canvas_q;
    pad_d    = pad_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CANVAS_SIZE: begin
          canvas_d = (cfg_wdata_i[13:0] > MAX_CANVAS) ? MAX_CANVAS : cfg_wdata_i[13:0];
        end
        REG_PAD: begin
          pad_d = cfg_wdata_i[7:0];
        end
        default: begin
          canvas_d = canvas_q;
          pad_d    = pad_q;
        end
      endcase
    end
  end

  // Register storage with reset defaults.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_q <= 14'd1024;
      pad_q    <= 8'd2;
    end else begin
      canvas_q <= canvas_d;
      pad_q    <= pad_d;
    end
  end

  assign cfg_o.canvas_size = canvas_q;
  assign cfg_o.pad         = pad_q;

endmodule

### rtl/sap_core.sv
// Placement logic and packing state: shelf cursor, shelf top, height, page, area.
module sap_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  sap_pkg::in_req_t  req_i,
  input  sap_pkg::cfg_t     cfg_i,
  output sap_pkg::out_rsp_t rsp_o
);
  import sap_pkg::*;

  // The cursor can run past the page edge after the page shrinks, so it keeps full range.
  logic [31:0] cursor_q, cursor_d;
  logic [13:0] top_q, top_d;
  logic [13:0] height_q, height_d;
  logic [3:0]  page_q, page_d;
  logic [26:0] area_q, area_d;

  logic [31:0] cx_b;
  logic [13:0] st_b, sh_b;
  logic [3:0]  pg_b;
  logic [26:0] area_b;
  logic [14:0] wp, hp;
  logic        too_big;
  logic        cx_in;
  logic [15:0] wp_cx;
  logic        need_shelf;
  logic [15:0] shelf_next;
  logic        np_a, np_b, new_page, last_page;
  logic [15:0] st1;
  logic [13:0] sh1, sh2;
  logic [31:0] cx1, cx2;
  logic [12:0] x_pl, y_pl;
  logic [27:0] prod;

  // State as seen by this request, after an optional restart.
  always_comb begin
    if (req_i.restart) begin
      cx_b   = '0;
      st_b   = '0;
      sh_b   = '0;
      pg_b   = '0;
      area_b = '0;
    end else begin
      cx_b   = cursor_q;
      st_b   = top_q;
      sh_b   = height_q;
      pg_b   = page_q;
      area_b = area_q;
    end
  end

  // Fit checks against the page edge.
  always_comb begin
    wp      = {1'b0, req_i.rect_w} + {7'd0, cfg_i.pad};
    hp      = {1'b0, req_i.rect_h} + {7'd0, cfg_i.pad};
    too_big = (wp > {1'b0, cfg_i.canvas_size}) || (hp > {1'b0, cfg_i.canvas_size});

    // A cursor beyond the edge never triggers a new shelf.
    cx_in      = cx_b <= {18'd0, cfg_i.canvas_size};
    wp_cx      = {1'b0, wp} + {1'b0, cx_b[14:0]};
    need_shelf = cx_in && (wp_cx > {2'd0, cfg_i.canvas_size});

    shelf_next = {2'd0, st_b} + {2'd0, sh_b} + {8'd0, cfg_i.pad};
    np_a = need_shelf &&
           (({1'b0, shelf_next} + {9'd0, cfg_i.pad}) > {3'd0, cfg_i.canvas_size});

    st1 = need_shelf ? shelf_next : {2'd0, st_b};
    sh1 = need_shelf ? 14'd0 : sh_b;
    cx1 = need_shelf ? 32'd0 : cx_b;

    sh2  = (req_i.rect_h > sh1) ? req_i.rect_h : sh1;
    np_b = ({1'b0, st1} + {3'd0, sh2} + {9'd0, cfg_i.pad}) > {3'd0, cfg_i.canvas_size};

    new_page  = np_a || np_b;
    last_page = ({1'b0, pg_b} + 5'd1) >= PAGE_LIMIT;

    x_pl = cx1[12:0] + {5'd0, cfg_i.pad};
    y_pl = st1[12:0] + {5'd0, cfg_i.pad};
    cx2  = cx1 + {17'd0, wp};
    prod = {14'd0, req_i.rect_w} * {14'd0, req_i.rect_h};
  end

  // Next state and result.
  always_comb begin
    cursor_d = cx_b;
    top_d    = st_b;
    height_d = sh_b;
    page_d   = pg_b;
    area_d   = area_b;

    rsp_o.pos_x      = '0;
    rsp_o.pos_y      = '0;
    rsp_o.page_index = pg_b;
    rsp_o.status     = ST_PLACED;
    rsp_o.used_area  = area_b;

    if (too_big) begin
      rsp_o.status = ST_TOO_BIG;
    end else if (new_page && last_page) begin
      rsp_o.status = ST_NO_PAGE;
    end else if (new_page) begin
      // Start the next page with this rectangle at the padded corner.
      page_d   = pg_b + 4'd1;
      cursor_d = {17'd0, wp};
      top_d    = '0;
      height_d = req_i.rect_h;
      area_d   = prod[26:0];
      rsp_o.pos_x      = {5'd0, cfg_i.pad};
      rsp_o.pos_y      = {5'd0, cfg_i.pad};
      rsp_o.page_index = pg_b + 4'd1;
      rsp_o.used_area  = prod[26:0];
    end else begin
      cursor_d = cx2;
      top_d    = st1[13:0];
      height_d = sh2;
      area_d   = area_b + prod[26:0];
      rsp_o.pos_x     = x_pl;
      rsp_o.pos_y     = y_pl;
      rsp_o.used_area = area_b + prod[26:0];
    end
  end

  // Packing state advances once per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      top_q    <= '0;
      height_q <= '0;
      page_q   <= '0;
      area_q   <= '0;
    end else if (step_i) begin
      cursor_q <= cursor_d;
      top_q    <= top_d;
      height_q <= height_d;
      page_q   <= page_d;
      area_q   <= area_d;
    end
  end

endmodule

### rtl/sap_checker.sv
// Port-level checks for the shelf atlas packer, bound to the top level.
module sap_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input sap_pkg::out_rsp_t out_rsp_o
);
  import sap_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_rsp_o))
    else $error("result changed while stalled");

  // The input side only stalls when a result is blocked downstream.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without downstream backpressure");

  // Every accepted request, once it has passed the input register, is followed by an offered result.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##1 out_valid_o)
    else $error("no result after accepted request");

  // Rejected rectangles report a zero position.
  a_err_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == ST_TOO_BIG || out_rsp_o.status == ST_NO_PAGE)
      |-> out_rsp_o.pos_x == 13'd0 && out_rsp_o.pos_y == 13'd0)
    else $error("rejected rectangle with nonzero position");

endmodule

bind shelf_atlas_packer_top sap_checker u_sap_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
